[design/bda_pkg.sv]
// Shared constants, types and helper functions for the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
package bda_pkg;

  localparam int ORDERS     = 11;
  localparam int TOP        = ORDERS - 1;
  localparam int UNITS      = 1 << TOP;
  localparam int UA_W       = TOP;
  localparam int ORD_W      = $clog2(ORDERS);
  localparam int AO_W       = $clog2(ORDERS + 1);
  localparam int WORD_SHIFT = (TOP > 5) ? 5 : TOP - 1;
  localparam int WORD_W     = 1 << WORD_SHIFT;
  localparam int ROWS       = UNITS / WORD_W;
  localparam int BIT_W      = (WORD_SHIFT < 1) ? 1 : WORD_SHIFT;
  localparam int ROW_W      = ($clog2(ROWS) < 1) ? 1 : $clog2(ROWS);
  localparam int FM_AW      = ORD_W + ROW_W;
  localparam int FM_DEPTH   = 1 << FM_AW;
  localparam int CLR_N      = (UNITS > FM_DEPTH) ? UNITS : FM_DEPTH;
  localparam int CLR_W      = $clog2(CLR_N);

  localparam logic [AO_W-1:0] NOT_ALLOC = '1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  // Free-map row address of block i at order o.
  function automatic logic [FM_AW-1:0] fm_addr(logic [ORD_W-1:0] o, logic [UA_W-1:0] i);
    logic [ROW_W-1:0] r;
    r = ROW_W'(i >> WORD_SHIFT);
    return {o, r};
  endfunction

  // Position of block i inside its free-map row.
  function automatic logic [BIT_W-1:0] bit_of(logic [UA_W-1:0] i);
    logic [UA_W-1:0] m;
    m = i & UA_W'(WORD_W - 1);
    return BIT_W'(m);
  endfunction

  function automatic logic [WORD_W-1:0] bit_mask(logic [BIT_W-1:0] b);
    logic [WORD_W-1:0] one;
    one = WORD_W'(1);
    return one << b;
  endfunction

  function automatic logic [BIT_W-1:0] low_bit(logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) r = BIT_W'(k);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] low_row(logic [ROWS-1:0] v);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int k = ROWS - 1; k >= 0; k--) begin
      if (v[k]) r = ROW_W'(k);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/bda_req_if.sv]
// Request channel: valid/ready handshake with allocate or free payload.
`timescale 1ns / 1ps
`default_nettype none
interface bda_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [10:0] request_units;
  logic [9:0]  free_address;

  modport source (output valid, mode, request_units, free_address, input ready);
  modport sink (input valid, mode, request_units, free_address, output ready);
endinterface
`default_nettype wire

[design/bda_rsp_if.sv]
// Response channel: valid/ready handshake with block address, order and status.
`timescale 1ns / 1ps
`default_nettype none
interface bda_rsp_if;
  logic       valid;
  logic       ready;
  logic [9:0] block_address;
  logic [3:0] block_order;
  logic [1:0] status;

  modport source (output valid, block_address, block_order, status, input ready);
  modport sink (input valid, block_address, block_order, status, output ready);
endinterface
`default_nettype wire

[design/buddy_allocator.sv]
// Buddy allocator: free-map and allocation-order memories with a sequencing FSM.
//
// Usage: requests arrive on req (mode 0 allocate request_units, mode 1 free
// free_address); one response beat per request leaves on rsp with the block's
// base unit, its order and a status (ok, out of memory, bad free).
// The free map is a synchronous memory of 32-bit rows, one row set per order,
// with a flip-flop per row telling whether it holds any free block; the order
// of each allocated block sits in a second memory indexed by base unit.
// One request is in flight at a time. An allocation finds and takes a free
// block, splits it level by level down to the wanted order and records the
// order; a free reads and clears the block's order, merges with free buddies
// and marks the final block free; a rejected request writes neither memory.
// Each tree level costs a memory read-modify-write. After rst the block
// sweeps both memories, one address a cycle, over the larger of the unit
// count and the free-map depth; req.ready stays low meanwhile. A finished
// response waits in the output register while rsp.ready is low; a new request
// can be taken in that wait, and its response holds until the register drains.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator
  import bda_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  bda_req_if.sink   req,
  bda_rsp_if.source rsp
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_AFIND = 14'b00000000000100,
    S_ATAKE = 14'b00000000001000,
    S_SRD   = 14'b00000000010000,
    S_SWR   = 14'b00000000100000,
    S_AREC  = 14'b00000001000000,
    S_FRD   = 14'b00000010000000,
    S_FCHK  = 14'b00000100000000,
    S_MRD   = 14'b00001000000000,
    S_MCHK  = 14'b00010000000000,
    S_SETRD = 14'b00100000000000,
    S_SETWR = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  logic [WORD_W-1:0] fm_mem [FM_DEPTH];
  logic [AO_W-1:0]   ao_mem [UNITS];

  logic [FM_AW-1:0]  fm_ra, fm_wa;
  logic [WORD_W-1:0] fm_wd, fm_rd;
  logic              fm_we;
  logic [UA_W-1:0]   ao_ra, ao_wa;
  logic [AO_W-1:0]   ao_wd, ao_rd;
  logic              ao_we;

  logic [ROWS-1:0]   ne [ORDERS];

  logic [CLR_W-1:0]  clr;
  logic [ORD_W-1:0]  ord, want, ford;
  logic [UA_W-1:0]   idx, base, faddr;
  logic [ROW_W-1:0]  arow;

  logic [UA_W-1:0]   res_addr;
  logic [ORD_W-1:0]  res_ord;
  status_t           res_st;

  logic              ovalid;
  logic [9:0]        oaddr;
  logic [3:0]        oord;
  logic [1:0]        ost;

  // Request decode
  logic [10:0] units_eff, units_m1;
  logic [3:0]  want_raw;
  always_comb begin
    units_eff = (req.request_units == 11'd0) ? 11'd1 : req.request_units;
    units_m1  = units_eff - 11'd1;
    want_raw  = 4'd0;
    for (int k = 0; k < 11; k++) begin
      if (units_m1[k]) want_raw = 4'(k + 1);
    end
  end

  // Smallest non-empty order at or above the wanted one
  logic             hit;
  logic [ORD_W-1:0] found_o;
  always_comb begin
    hit     = 1'b0;
    found_o = '0;
    for (int o = 0; o < ORDERS; o++) begin
      if (!hit && int'(want) <= o && |ne[o]) begin
        hit     = 1'b1;
        found_o = ORD_W'(o);
      end
    end
  end

  logic [ROW_W-1:0]  found_row;
  logic [BIT_W-1:0]  take_bit;
  logic [UA_W-1:0]   take_idx;
  logic [UA_W-1:0]   buddy;
  logic [AO_W-1:0]   ao_top;
  logic              out_free;
  logic [FM_AW-1:0]  root_addr;

  assign found_row = low_row(ne[found_o]);
  assign take_bit  = low_bit(fm_rd);
  assign take_idx  = UA_W'((UA_W'(arow) << WORD_SHIFT) | UA_W'(take_bit));
  assign buddy     = idx ^ UA_W'(1);
  assign ao_top    = AO_W'(TOP);
  assign out_free  = !ovalid || rsp.ready;
  assign root_addr = fm_addr(ORD_W'(TOP), '0);

  // Memory port control and next state
  always_comb begin
    state_next = state;
    fm_ra = fm_addr(ord, idx);
    fm_we = 1'b0;
    fm_wa = fm_addr(ord, idx);
    fm_wd = fm_rd;
    ao_ra = faddr;
    ao_we = 1'b0;
    ao_wa = base;
    ao_wd = NOT_ALLOC;
    unique case (state)
      S_CLEAR: begin
        fm_we = (32'(clr) < FM_DEPTH);
        fm_wa = FM_AW'(clr);
        fm_wd = (FM_AW'(clr) == root_addr) ? WORD_W'(1) : '0;
        ao_we = (32'(clr) < UNITS);
        ao_wa = UA_W'(clr);
        ao_wd = NOT_ALLOC;
        if (32'(clr) == CLR_N - 1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          if (req.mode == MODE_ALLOC) begin
            state_next = (int'(want_raw) > TOP) ? S_DONE : S_AFIND;
          end else begin
            state_next = (32'(req.free_address) >= UNITS) ? S_DONE : S_FRD;
          end
        end
      end
      S_AFIND: begin
        fm_ra      = {found_o, found_row};
        state_next = hit ? S_ATAKE : S_DONE;
      end
      S_ATAKE: begin
        fm_we      = 1'b1;
        fm_wa      = {ord, arow};
        fm_wd      = fm_rd & ~bit_mask(take_bit);
        state_next = (ord == want) ? S_AREC : S_SRD;
      end
      S_SRD: begin
        fm_ra      = fm_addr(ord - ORD_W'(1), UA_W'(idx << 1) | UA_W'(1));
        state_next = S_SWR;
      end
      S_SWR: begin
        fm_we      = 1'b1;
        fm_wa      = fm_addr(ord, idx | UA_W'(1));
        fm_wd      = fm_rd | bit_mask(bit_of(idx | UA_W'(1)));
        state_next = (ord == want) ? S_AREC : S_SRD;
      end
      S_AREC: begin
        ao_we      = 1'b1;
        ao_wa      = base;
        ao_wd      = AO_W'(want);
        state_next = S_DONE;
      end
      S_FRD: begin
        ao_ra      = faddr;
        state_next = S_FCHK;
      end
      S_FCHK: begin
        ao_we      = (ao_rd <= ao_top);
        ao_wa      = faddr;
        ao_wd      = NOT_ALLOC;
        state_next = (ao_rd <= ao_top) ? S_MRD : S_DONE;
      end
      S_MRD: begin
        fm_ra      = fm_addr(ord, buddy);
        state_next = (32'(ord) == TOP) ? S_SETRD : S_MCHK;
      end
      S_MCHK: begin
        fm_we      = fm_rd[bit_of(buddy)];
        fm_wa      = fm_addr(ord, buddy);
        fm_wd      = fm_rd & ~bit_mask(bit_of(buddy));
        state_next = fm_rd[bit_of(buddy)] ? S_MRD : S_SETRD;
      end
      S_SETRD: begin
        fm_ra      = fm_addr(ord, idx);
        state_next = S_SETWR;
      end
      S_SETWR: begin
        fm_we      = 1'b1;
        fm_wa      = fm_addr(ord, idx);
        fm_wd      = fm_rd | bit_mask(bit_of(idx));
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    fm_rd <= fm_mem[fm_ra];
    if (ao_we) ao_mem[ao_wa] <= ao_wd;
    ao_rd <= ao_mem[ao_ra];
  end

  // Row occupancy flags track every free-map write outside the reset sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int o = 0; o < ORDERS; o++) ne[o] <= (o == TOP) ? ROWS'(1) : '0;
    end else if (fm_we && state != S_CLEAR) begin
      ne[fm_wa[FM_AW-1 -: ORD_W]][fm_wa[ROW_W-1:0]] <= |fm_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr <= clr + CLR_W'(1);
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        want     <= ORD_W'(want_raw);
        faddr    <= UA_W'(req.free_address);
        res_addr <= '0;
        res_ord  <= '0;
        res_st   <= (req.mode == MODE_ALLOC) ? ST_OOM : ST_BAD_FREE;
      end
      S_AFIND: begin
        ord  <= found_o;
        arow <= found_row;
      end
      S_ATAKE: begin
        idx  <= take_idx;
        base <= UA_W'(take_idx << ord);
      end
      S_SRD: begin
        ord <= ord - ORD_W'(1);
        idx <= UA_W'(idx << 1);
      end
      S_AREC: begin
        res_addr <= base;
        res_ord  <= want;
        res_st   <= ST_OK;
      end
      S_FCHK: begin
        ford <= ORD_W'(ao_rd);
        ord  <= ORD_W'(ao_rd);
        idx  <= faddr >> ao_rd;
      end
      S_MCHK: begin
        if (fm_rd[bit_of(buddy)]) begin
          idx <= idx >> 1;
          ord <= ord + ORD_W'(1);
        end
      end
      S_SETWR: begin
        res_addr <= faddr;
        res_ord  <= ford;
        res_st   <= ST_OK;
      end
      default: ;
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      ovalid <= 1'b1;
    end else if (rsp.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      oaddr <= 10'(res_addr);
      oord  <= 4'(res_ord);
      ost   <= res_st;
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = ovalid;
  assign rsp.block_address = oaddr;
  assign rsp.block_order   = oord;
  assign rsp.status        = ost;

`ifndef SYNTH
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_ATAKE |-> fm_rd != '0)
    else $error("flagged free-map row read back empty");

  a_merge_below_top: assert property (@(posedge clk) disable iff (rst)
    state == S_MCHK |-> 32'(ord) < TOP)
    else $error("merge step at the root order");

  a_ok_aligned: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OK |->
      32'(rsp.block_order) <= TOP &&
      (32'(rsp.block_address) & ((32'd1 << rsp.block_order) - 32'd1)) == 32'd0)
    else $error("ok response with a misaligned or oversized block");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.block_address == '0 && rsp.block_order == '0)
    else $error("error response carries a nonzero block");
`endif

endmodule
`default_nettype wire

[tb/buddy_allocator_tb.sv]
// Self-checking testbench for the buddy allocator: directed and random allocate/free traffic.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator_tb;
  import bda_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [9:0] address;
    logic [3:0] order;
    status_t    status;
  } alloc_result_t;

  logic clk;
  logic rst;
  bda_req_if req ();
  bda_rsp_if rsp ();

  buddy_allocator DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // Predictor state: one free bit per tree node, indexed [order][block].
  bit            node_free [ORDERS][UNITS];
  logic [3:0]    base_order [UNITS];
  alloc_result_t expected_q [$];
  int unsigned   live_bases [$];

  int errors;
  int checked;
  int idle_cycles;
  int n_oom, n_bad, n_merge_frees;
  bit stall_heavy;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void model_reset();
    for (int o = 0; o < ORDERS; o++)
      for (int i = 0; i < UNITS; i++) node_free[o][i] = 1'b0;
    for (int u = 0; u < UNITS; u++) base_order[u] = 4'hF;
    node_free[TOP][0] = 1'b1;
    live_bases.delete();
  endfunction

  function automatic alloc_result_t predict_alloc(int units);
    alloc_result_t r;
    int want;
    int idx;
    int base;
    r = '{address: '0, order: '0, status: ST_OOM};
    if (units == 0) units = 1;
    want = 0;
    while ((1 << want) < units) want++;
    if (want > TOP) return r;
    for (int o = want; o <= TOP; o++) begin
      for (int i = 0; i < (1 << (TOP - o)); i++) begin
        if (node_free[o][i]) begin
          node_free[o][i] = 1'b0;
          base = i << o;
          idx = i;
          // split down, release each right half
          for (int lv = o - 1; lv >= want; lv--) begin
            idx = idx << 1;
            node_free[lv][idx + 1] = 1'b1;
          end
          base_order[base] = 4'(want);
          live_bases.push_back(base);
          r = '{address: 10'(base), order: 4'(want), status: ST_OK};
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic alloc_result_t predict_free(int addr);
    alloc_result_t r;
    int o;
    int idx;
    r = '{address: '0, order: '0, status: ST_BAD_FREE};
    if (base_order[addr] > TOP) return r;
    o = base_order[addr];
    r = '{address: 10'(addr), order: 4'(o), status: ST_OK};
    base_order[addr] = 4'hF;
    foreach (live_bases[k]) if (live_bases[k] == addr) begin
      live_bases.delete(k);
      break;
    end
    idx = addr >> o;
    if (o < TOP && node_free[o][idx ^ 1]) n_merge_frees++;
    while (o < TOP && node_free[o][idx ^ 1]) begin
      node_free[o][idx ^ 1] = 1'b0;
      idx = idx >> 1;
      o++;
    end
    node_free[o][idx] = 1'b1;
    return r;
  endfunction

  // Send one request beat and queue its prediction.
  task automatic send_request(logic m, int units, int addr);
    alloc_result_t r;
    int g;
    g = gap_len();
    // drop valid only when a gap follows the previous beat
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.mode          <= m;
    req.request_units <= 11'(units);
    req.free_address  <= 10'(addr);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = (m == MODE_ALLOC) ? predict_alloc(units) : predict_free(addr);
    if (r.status == ST_OOM) n_oom++;
    if (r.status == ST_BAD_FREE) n_bad++;
    expected_q.push_back(r);
  endtask

  task automatic alloc_units(int units);
    send_request(MODE_ALLOC, units, $urandom_range(0, 1023));
  endtask

  task automatic free_addr(int addr);
    send_request(MODE_FREE, $urandom_range(0, 2047), addr);
  endtask

  task automatic free_random_live();
    int k;
    k = $urandom_range(0, live_bases.size() - 1);
    free_addr(live_bases[k]);
  endtask

  task automatic test_extremes();
    alloc_units(0);
    alloc_units(1024);
    alloc_units(2047);
    alloc_units(1025);
    free_addr(1023);
    free_addr(0);
    free_addr(0);
    alloc_units(1024);
    alloc_units(1);
    free_addr(0);
    free_addr(0);
  endtask

  task automatic test_split_merge();
    alloc_units(1);
    alloc_units(3);
    alloc_units(512);
    alloc_units(300);
    alloc_units(2);
    free_addr(4);
    free_addr(0);
    free_addr(2);
    free_addr(5);
    free_addr(512);
    alloc_units(1024);
    free_addr(0);
  endtask

  task automatic test_random_traffic(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) stall_heavy = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        // mostly small sizes, a few large
        if ($urandom_range(0, 9) == 0) alloc_units($urandom_range(0, 2047));
        else alloc_units($urandom_range(0, 16));
      end else if (r < 88 && live_bases.size() > 0) begin
        free_random_live();
      end else begin
        free_addr($urandom_range(0, 1023));
      end
    end
    // drain so the pool returns to one block
    while (live_bases.size() > 0) free_random_live();
    alloc_units(1024);
    free_addr(0);
  endtask

  initial begin
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.mode          = MODE_ALLOC;
    req.request_units = '0;
    req.free_address  = '0;
    errors = 0; checked = 0; n_oom = 0; n_bad = 0; n_merge_frees = 0;
    stall_heavy = 1'b0;
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_split_merge();
    test_random_traffic(440);
    req.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d responses: %0d out-of-memory, %0d bad frees, %0d merging frees.",
             checked, n_oom, n_bad, n_merge_frees);
    if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Response ready with random stalls.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_heavy) rsp.ready <= (gap_len() == 0);
      else rsp.ready <= ($urandom_range(0, 9) != 0);
    end
  end

  // Compare each response beat against the oldest prediction.
  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      checked <= checked + 1;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response addr=%0d order=%0d status=%0d", $time,
                 rsp.block_address, rsp.block_order, rsp.status);
        errors <= errors + 1;
      end else begin
        e = expected_q.pop_front();
        if (rsp.block_address !== e.address || rsp.block_order !== e.order ||
            rsp.status !== e.status) begin
          $display("%0t: mismatch expected addr=%0d order=%0d status=%0d, got %0d %0d %0d",
                   $time, e.address, e.order, e.status,
                   rsp.block_address, rsp.block_order, rsp.status);
          errors <= errors + 1;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side; reset sweep included.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
`default_nettype wire
